[rtl/mh2_pkg.sv]
`default_nettype none

package mh2_pkg;

    localparam int unsigned DefMaxKeyBytes = 1024;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NBYTE_W = 3;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned PC_W    = 3;

    typedef logic [PC_W-1:0] t_pc;

    // multiplier operand select
    typedef logic [2:0] t_msel;
    localparam t_msel MS_K  = 3'd0;   // k
    localparam t_msel MS_KX = 3'd1;   // k ^ (k >> 24)
    localparam t_msel MS_H  = 3'd2;   // h
    localparam t_msel MS_HT = 3'd3;   // h ^ tail bytes
    localparam t_msel MS_HF = 3'd4;   // h ^ (h >> 13)

    // hash register source
    typedef logic [1:0] t_hsrc;
    localparam t_hsrc HS_MUL  = 2'd0;
    localparam t_hsrc HS_MULK = 2'd1;
    localparam t_hsrc HS_HOLD = 2'd2;

    // sequencing of a microword
    typedef logic [1:0] t_sq;
    localparam t_sq SQ_NEXT = 2'd0;   // go to nxt
    localparam t_sq SQ_LAST = 2'd1;   // go to nxt on last word, else end
    localparam t_sq SQ_EMIT = 2'd2;   // wait for output slot, end

    // microcode addresses
    localparam t_pc UA_KMUL = 3'd0;
    localparam t_pc UA_KMIX = 3'd1;
    localparam t_pc UA_HMIX = 3'd2;
    localparam t_pc UA_TAIL = 3'd3;
    localparam t_pc UA_FIN  = 3'd4;
    localparam t_pc UA_OUT  = 3'd5;

    typedef struct packed {
        t_msel msel;
        logic  wr_k;
        t_hsrc hsrc;
        t_sq   sq;
        logic  emit;
        t_pc   nxt;
    } t_ucode;

    // sequencer to datapath control
    typedef struct packed {
        logic   load;     // input transfer this cycle
        logic   exec;     // microword executes this cycle
        t_ucode uc;
    } t_ctrl;

    function automatic t_ucode ucode_rom(input t_pc pc);
        t_ucode w;
        w = '{msel: MS_K, wr_k: 1'b0, hsrc: HS_HOLD, sq: SQ_EMIT,
              emit: 1'b0, nxt: UA_KMUL};
        unique case (pc)
            UA_KMUL: w = '{msel: MS_K,  wr_k: 1'b1, hsrc: HS_HOLD, sq: SQ_NEXT,
                           emit: 1'b0, nxt: UA_KMIX};
            UA_KMIX: w = '{msel: MS_KX, wr_k: 1'b1, hsrc: HS_HOLD, sq: SQ_NEXT,
                           emit: 1'b0, nxt: UA_HMIX};
            UA_HMIX: w = '{msel: MS_H,  wr_k: 1'b0, hsrc: HS_MULK, sq: SQ_LAST,
                           emit: 1'b0, nxt: UA_FIN};
            UA_TAIL: w = '{msel: MS_HT, wr_k: 1'b0, hsrc: HS_MUL,  sq: SQ_NEXT,
                           emit: 1'b0, nxt: UA_FIN};
            UA_FIN:  w = '{msel: MS_HF, wr_k: 1'b0, hsrc: HS_MUL,  sq: SQ_NEXT,
                           emit: 1'b0, nxt: UA_OUT};
            UA_OUT:  w = '{msel: MS_K,  wr_k: 1'b0, hsrc: HS_HOLD, sq: SQ_EMIT,
                           emit: 1'b1, nxt: UA_KMUL};
            default: w = '{msel: MS_K,  wr_k: 1'b0, hsrc: HS_HOLD, sq: SQ_EMIT,
                           emit: 1'b0, nxt: UA_KMUL};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/mh2_seq.sv]
`default_nettype none

module mh2_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [mh2_pkg::NBYTE_W-1:0] i_bytes_valid,
    input  wire logic                        i_last_word,
    input  wire logic                        i_out_free,
    output logic                             o_busy,
    output mh2_pkg::t_ctrl                   o_ctrl
);
    import mh2_pkg::*;

    logic   r_busy, n_busy;
    t_pc    r_pc, n_pc;
    logic   r_last, n_last;
    t_ucode uc;
    logic   accept;
    logic   step_en;
    logic   nb_full;
    logic   nb_zero;

    assign uc      = ucode_rom(r_pc);
    assign accept  = i_in_valid && !r_busy;
    assign nb_full = i_bytes_valid >= NBYTE_W'(4);
    assign nb_zero = i_bytes_valid == '0;
    assign step_en = r_busy && (!uc.emit || i_out_free);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_last = r_last;
        if (accept) begin
            n_busy = 1'b1;
            // a short word always ends the key
            n_last = i_last_word || !nb_full;
            priority if (nb_full) begin
                n_pc = UA_KMUL;
            end else if (nb_zero) begin
                n_pc = UA_FIN;
            end else begin
                n_pc = UA_TAIL;
            end
        end else if (step_en) begin
            unique case (uc.sq)
                SQ_NEXT: n_pc = uc.nxt;
                SQ_LAST: begin
                    if (r_last) begin
                        n_pc = uc.nxt;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                SQ_EMIT: n_busy = 1'b0;
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UA_KMUL;
            r_last <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_last <= n_last;
        end
    end

    assign o_busy      = r_busy;
    assign o_ctrl.load = accept;
    assign o_ctrl.exec = step_en;
    assign o_ctrl.uc   = uc;

endmodule

`default_nettype wire

[rtl/mh2_dp.sv]
`default_nettype none

module mh2_dp #(
    parameter int unsigned MAX_KEY_BYTES = mh2_pkg::DefMaxKeyBytes
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mh2_pkg::t_ctrl              i_ctrl,
    input  wire logic [mh2_pkg::WORD_W-1:0]  i_key_word,
    input  wire logic [mh2_pkg::NBYTE_W-1:0] i_bytes_valid,
    input  wire logic [mh2_pkg::LEN_W-1:0]   i_key_length,
    input  wire logic                        i_seed_wr,
    input  wire logic [mh2_pkg::WORD_W-1:0]  i_seed,
    input  wire logic                        i_out_stall,
    output logic                             o_out_free,
    output logic                             o_out_valid,
    output logic [mh2_pkg::WORD_W-1:0]       o_hash
);
    import mh2_pkg::*;

    localparam logic [WORD_W-1:0] MaxLen = WORD_W'(MAX_KEY_BYTES);

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_h, n_h;
    logic [WORD_W-1:0] r_k, n_k;
    logic              r_kip;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_hash;

    logic [WORD_W-1:0] len_ext;
    logic [WORD_W-1:0] h_start;
    logic [WORD_W-1:0] word_mask;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] prod;
    logic              out_free;

    assign len_ext = {{(WORD_W-LEN_W){1'b0}}, i_key_length};
    assign h_start = r_kip ? r_h : (r_seed ^ ((len_ext > MaxLen) ? MaxLen : len_ext));

    always_comb begin
        unique case (i_bytes_valid)
            3'd1:    word_mask = 32'h0000_00ff;
            3'd2:    word_mask = 32'h0000_ffff;
            3'd3:    word_mask = 32'h00ff_ffff;
            default: word_mask = 32'hffff_ffff;
        endcase
    end

    // one shared constant multiplier
    always_comb begin
        unique case (i_ctrl.uc.msel)
            MS_K:    mul_a = r_k;
            MS_KX:   mul_a = r_k ^ (r_k >> MIX_SHIFT);
            MS_H:    mul_a = r_h;
            MS_HT:   mul_a = r_h ^ r_k;
            MS_HF:   mul_a = r_h ^ (r_h >> FIN_SHIFT_A);
            default: mul_a = r_k;
        endcase
    end

    assign prod = mul_a * MIX_MUL;

    always_comb begin
        n_h = r_h;
        n_k = r_k;
        if (i_ctrl.load) begin
            n_h = h_start;
            n_k = i_key_word & word_mask;
        end else if (i_ctrl.exec) begin
            if (i_ctrl.uc.wr_k) begin
                n_k = prod;
            end
            unique case (i_ctrl.uc.hsrc)
                HS_MUL:  n_h = prod;
                HS_MULK: n_h = prod ^ r_k;
                HS_HOLD: n_h = r_h;
                default: n_h = r_h;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_k <= n_k;
        if (i_ctrl.exec && i_ctrl.uc.emit) begin
            r_out_hash <= r_h ^ (r_h >> FIN_SHIFT_B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_kip       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_wr) begin
                r_seed <= i_seed;
            end
            if (i_ctrl.load) begin
                r_kip <= 1'b1;
            end else if (i_ctrl.exec && i_ctrl.uc.emit) begin
                r_kip <= 1'b0;
            end
            if (i_ctrl.exec && i_ctrl.uc.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_free  = out_free;
    assign o_out_valid = r_out_valid;
    assign o_hash      = r_out_hash;

endmodule

`default_nettype wire

[rtl/murmur2_hash_32_top.sv]
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+----------------------------------------
// in       | sink      | i_in_valid / o_in_stall   | i_key_word, i_bytes_valid, i_key_length,
//          |           |                           | i_last_word
// out      | source    | o_out_valid / i_out_stall | o_hash_value, o_hash_last
// cfg      | sink      | i_cfg_valid / o_cfg_ready | i_seed_value
//
// a full word that does not end the key is loaded, then runs three microcode steps
// (KMUL, KMIX, HMIX), all through the one constant multiplier; a full last word goes
// on through FIN and OUT, a 1..3 byte tail runs TAIL, FIN, OUT and an empty key FIN, OUT
// synchronous active-low reset clears the sequencer, key flag, seed and output valid
// a stalled output only holds the sequencer in its final step; a finished hash waits
// in the output register while the next key word is taken in

module murmur2_hash_32_top #(
    parameter int unsigned MAX_KEY_BYTES = mh2_pkg::DefMaxKeyBytes
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input word transfer
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mh2_pkg::WORD_W-1:0]  i_key_word,
    input  wire logic [mh2_pkg::NBYTE_W-1:0] i_bytes_valid,
    input  wire logic [mh2_pkg::LEN_W-1:0]   i_key_length,
    input  wire logic                        i_last_word,
    // hash result transfer
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [mh2_pkg::WORD_W-1:0]       o_hash_value,
    output logic                             o_hash_last,
    // seed register write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [mh2_pkg::WORD_W-1:0]  i_seed_value
);
    import mh2_pkg::*;

    t_ctrl ctrl;
    logic  busy;
    logic  out_free;

    // step counter and microcode rom
    mh2_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_bytes_valid (i_bytes_valid),
        .i_last_word   (i_last_word),
        .i_out_free    (out_free),
        .o_busy        (busy),
        .o_ctrl        (ctrl)
    );

    // hash and mix registers, shared multiplier, output register
    mh2_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_key_word    (i_key_word),
        .i_bytes_valid (i_bytes_valid),
        .i_key_length  (i_key_length),
        .i_seed_wr     (i_cfg_valid),
        .i_seed        (i_seed_value),
        .i_out_stall   (i_out_stall),
        .o_out_free    (out_free),
        .o_out_valid   (o_out_valid),
        .o_hash        (o_hash_value)
    );

    // one word at a time while the program runs
    assign o_in_stall  = busy;
    // seed writes are always taken
    assign o_cfg_ready = 1'b1;
    // every result closes a key
    assign o_hash_last = 1'b1;

endmodule

`default_nettype wire
